// File: hw/rtl/vkd_pkg.sv
// Shared constants, types and state codes of the vertex key dedup table.
package vkd_pkg;

   localparam int DEF_TABLE_SLOTS     = 2048;
   localparam int DEF_ATTR_INDEX_BITS = 20;
   localparam int VNUM_BITS           = 11;
   localparam int EPOCH_BITS          = 8;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } vkd_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage

// File: hw/rtl/vkd_if.sv
// Request and response channel interfaces of the vertex key dedup table.
interface vkd_req_if
   import vkd_pkg::*;
#(
   parameter int ATTR_INDEX_BITS = DEF_ATTR_INDEX_BITS
);
   logic                              valid;
   logic                              ready;
   logic                              start_of_model;
   logic        [ATTR_INDEX_BITS-1:0] position_index;
   logic signed [ATTR_INDEX_BITS:0]   nrm_index;
   logic signed [ATTR_INDEX_BITS:0]   texture_index;

   modport source (output valid, start_of_model, position_index, nrm_index,
                   texture_index, input ready);
   modport sink   (input valid, start_of_model, position_index, nrm_index,
                   texture_index, output ready);
endinterface

interface vkd_rsp_if
   import vkd_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [VNUM_BITS-1:0] vertex_number;
   logic                 is_new;
   logic                 table_full;

   modport source (output valid, vertex_number, is_new, table_full, input ready);
   modport sink   (input valid, vertex_number, is_new, table_full, output ready);
endinterface

// File: hw/rtl/vkd_table_mem.sv
// Slot memory: one address port shared by writes and reads, with registered read data.
module vkd_table_mem
   import vkd_pkg::*;
#(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int ENTRY_BITS  = EPOCH_BITS + 3 * DEF_ATTR_INDEX_BITS + 2 + VNUM_BITS
) (
   input  logic                           clock,
   input  mem_cmd_type                    mem_cmd,
   input  logic [$clog2(TABLE_SLOTS)-1:0] mem_addr,
   input  logic [ENTRY_BITS-1:0]          mem_wdata,
   output logic [ENTRY_BITS-1:0]          mem_rdata
);

   logic [ENTRY_BITS-1:0] slot_mem [TABLE_SLOTS];
   logic [ENTRY_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.rd_en) begin
         rdata_ff <= slot_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: hw/rtl/vkd_probe_ctrl.sv
// Probe sequencer: hashing, linear probe, insert, epoch and clear pass.
module vkd_probe_ctrl
   import vkd_pkg::*;
#(
   parameter int TABLE_SLOTS     = DEF_TABLE_SLOTS,
   parameter int ATTR_INDEX_BITS = DEF_ATTR_INDEX_BITS,
   parameter int ENTRY_BITS      = EPOCH_BITS + 3 * ATTR_INDEX_BITS + 2 + VNUM_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_start,
   input  logic [ATTR_INDEX_BITS-1:0]     req_pos,
   input  logic [ATTR_INDEX_BITS:0]       req_nrm,
   input  logic [ATTR_INDEX_BITS:0]       req_tex,
   input  logic                           res_free,
   output logic                           res_valid,
   output logic [VNUM_BITS-1:0]           res_vnum,
   output logic                           res_new,
   output logic                           res_full,
   output mem_cmd_type                    mem_cmd,
   output logic [$clog2(TABLE_SLOTS)-1:0] mem_addr,
   output logic [ENTRY_BITS-1:0]          mem_wdata,
   input  logic [ENTRY_BITS-1:0]          mem_rdata
);

   localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
   localparam int CNT_BITS  = SLOT_BITS + 1;
   localparam int KEY_BITS  = 3 * ATTR_INDEX_BITS + 2;
   localparam int HASH_BITS = (ATTR_INDEX_BITS + 3 > SLOT_BITS) ?
                              ATTR_INDEX_BITS + 3 : SLOT_BITS;

   vkd_state_type          state_ff, state_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [SLOT_BITS-1:0]   addr_ff, addr_in;
   logic [SLOT_BITS-1:0]   probe_ff, probe_in;
   logic [CNT_BITS-1:0]    fill_ff, fill_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic                   pend_ff, pend_in;

   logic [ATTR_INDEX_BITS-1:0] key_pos;
   logic [ATTR_INDEX_BITS:0]   key_nrm;
   logic [ATTR_INDEX_BITS:0]   key_tex;
   logic [HASH_BITS-1:0]       hash_wide;
   logic [SLOT_BITS-1:0]       home_slot;
   logic [EPOCH_BITS-1:0]      rd_tag;
   logic [KEY_BITS-1:0]        rd_key;
   logic [VNUM_BITS-1:0]       rd_vnum;
   logic [VNUM_BITS-1:0]       fill_vnum;
   logic                       slot_used;
   logic                       key_match;

   assign key_tex   = key_ff[ATTR_INDEX_BITS:0];
   assign key_nrm   = key_ff[2*ATTR_INDEX_BITS+1:ATTR_INDEX_BITS+1];
   assign key_pos   = key_ff[KEY_BITS-1:2*ATTR_INDEX_BITS+2];
   assign hash_wide = HASH_BITS'(key_pos) ^ (HASH_BITS'(key_nrm) << 1)
                    ^ (HASH_BITS'(key_tex) << 2);
   assign home_slot = hash_wide[SLOT_BITS-1:0];

   assign rd_tag    = mem_rdata[ENTRY_BITS-1 -: EPOCH_BITS];
   assign rd_key    = mem_rdata[VNUM_BITS +: KEY_BITS];
   assign rd_vnum   = mem_rdata[VNUM_BITS-1:0];
   assign fill_vnum = VNUM_BITS'(fill_ff);
   assign slot_used = (rd_tag == epoch_ff);
   assign key_match = (rd_key == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         fill_ff  <= '0;
         epoch_ff <= EPOCH_BITS'(1);
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         fill_ff  <= fill_in;
         epoch_ff <= epoch_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      probe_ff <= probe_in;
   end

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      addr_in   = addr_ff;
      probe_in  = probe_ff;
      fill_in   = fill_ff;
      epoch_in  = epoch_ff;
      pend_in   = pend_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res_vnum  = '0;
      res_new   = 1'b0;
      res_full  = 1'b0;
      mem_cmd   = '0;
      mem_addr  = addr_ff;
      mem_wdata = {epoch_ff, key_ff, fill_vnum};

      case (state_ff)
         ST_CLEAR: begin
            // tag 0 is never a live epoch
            mem_cmd.wr_en = 1'b1;
            mem_wdata     = '0;
            addr_in       = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               epoch_in = EPOCH_BITS'(1);
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = {req_pos, req_nrm, req_tex};
               probe_in = '0;
               state_in = ST_READ;
               if (req_start) begin
                  fill_in  = '0;
                  epoch_in = epoch_ff + 1'b1;
                  if (epoch_ff == '1) begin
                     addr_in  = '0;
                     pend_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_READ: begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = home_slot;
            addr_in       = home_slot;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (!slot_used) begin
               if (res_free) begin
                  mem_cmd.wr_en = 1'b1;
                  res_valid     = 1'b1;
                  res_vnum      = fill_vnum;
                  res_new       = 1'b1;
                  fill_in       = fill_ff + 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (key_match) begin
               if (res_free) begin
                  res_valid = 1'b1;
                  res_vnum  = rd_vnum;
                  state_in  = ST_IDLE;
               end
            end else if (probe_ff == '1) begin
               if (res_free) begin
                  res_valid = 1'b1;
                  res_full  = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               mem_cmd.rd_en = 1'b1;
               mem_addr      = addr_ff + 1'b1;
               addr_in       = addr_ff + 1'b1;
               probe_in      = probe_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/vertex_key_dedup_table_unit.sv
// Vertex key dedup table: hashed key-to-vertex-number map with output register.
// Flow: a taken request passes the read and check states; the check repeats per
// extra probe of the linear search (up to TABLE_SLOTS probes when full).
// One key in flight at a time; a new key waits until the last result is issued.
// Reset: synchronous; a pass clearing all TABLE_SLOTS slots runs before the
// first key, and again inside every 255th start_of_model key (epoch tag wrap).
module vertex_key_dedup_table_unit
   import vkd_pkg::*;
#(
   parameter int TABLE_SLOTS     = DEF_TABLE_SLOTS,
   parameter int ATTR_INDEX_BITS = DEF_ATTR_INDEX_BITS
) (
   input  logic            clock,
   input  logic            reset,
   vkd_req_if.sink         req_ch,
   vkd_rsp_if.source       rsp_ch
);

   localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
   localparam int ENTRY_BITS = EPOCH_BITS + 3 * ATTR_INDEX_BITS + 2 + VNUM_BITS;

   mem_cmd_type             mem_cmd;
   logic [SLOT_BITS-1:0]    mem_addr;
   logic [ENTRY_BITS-1:0]   mem_wdata;
   logic [ENTRY_BITS-1:0]   mem_rdata;
   logic                    res_free;
   logic                    res_valid;
   logic [VNUM_BITS-1:0]    res_vnum;
   logic                    res_new;
   logic                    res_full;

   logic                    rsp_valid_ff;
   logic [VNUM_BITS-1:0]    rsp_vnum_ff;
   logic                    rsp_new_ff;
   logic                    rsp_full_ff;

   vkd_probe_ctrl #(
      .TABLE_SLOTS     (TABLE_SLOTS),
      .ATTR_INDEX_BITS (ATTR_INDEX_BITS),
      .ENTRY_BITS      (ENTRY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_start (req_ch.start_of_model),
      .req_pos   (req_ch.position_index),
      .req_nrm   ($unsigned(req_ch.nrm_index)),
      .req_tex   ($unsigned(req_ch.texture_index)),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res_vnum  (res_vnum),
      .res_new   (res_new),
      .res_full  (res_full),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   vkd_table_mem #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_mem (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   assign res_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_vnum_ff <= res_vnum;
         rsp_new_ff  <= res_new;
         rsp_full_ff <= res_full;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.vertex_number = rsp_vnum_ff;
   assign rsp_ch.is_new        = rsp_new_ff;
   assign rsp_ch.table_full    = rsp_full_ff;

   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.rd_en && mem_cmd.wr_en))
      else $error("slot memory read and write in one cycle");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a key is in flight");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.table_full) |-> (rsp_ch.vertex_number == '0 && !rsp_ch.is_new))
      else $error("table full beat carries a vertex number");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_free)
      else $error("result produced while output register is occupied");

endmodule

// File: tb/sv/vertex_key_dedup_table_unit_tb.sv
// Self-checking testbench of the vertex key dedup table: random-gap driver, stalling receiver.
module vertex_key_dedup_table_unit_tb
   import vkd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = DEF_TABLE_SLOTS;
   localparam int AIB         = DEF_ATTR_INDEX_BITS;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int KW          = 3 * AIB + 2;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int LIMIT       = 1000000;
   localparam int RANDOM_ITEMS = 200;

   localparam logic [AIB:0]   NO_INDEX  = '1;
   localparam logic [AIB:0]   MAX_INDEX = {1'b0, {AIB{1'b1}}};
   localparam logic [AIB:0]   MIN_INDEX = {1'b1, {AIB{1'b0}}};
   localparam logic [AIB-1:0] MAX_POS   = '1;
   localparam logic [AIB-1:0] ZERO_POS  = '0;

   typedef struct {
      logic           som;
      logic [AIB-1:0] pos;
      logic [AIB:0]   nrm;
      logic [AIB:0]   tex;
      int             gap;
      bit             drain;
   } corner_beat_type;

   typedef struct packed {
      logic [VNUM_BITS-1:0] vnum;
      logic                 is_new;
      logic                 full;
   } vertex_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vkd_req_if #(.ATTR_INDEX_BITS(AIB)) req_ch ();
   vkd_rsp_if rsp_ch ();

   logic           drv_valid = 1'b0;
   logic           drv_som   = 1'b0;
   logic [AIB-1:0] drv_pos   = '0;
   logic [AIB:0]   drv_nrm   = '0;
   logic [AIB:0]   drv_tex   = '0;
   logic           rsp_ready = 1'b0;

   assign req_ch.valid          = drv_valid;
   assign req_ch.start_of_model = drv_som;
   assign req_ch.position_index = drv_pos;
   assign req_ch.nrm_index      = drv_nrm;
   assign req_ch.texture_index  = drv_tex;
   assign rsp_ch.ready          = rsp_ready;

   vertex_key_dedup_table_unit #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .ATTR_INDEX_BITS(AIB)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #6 clock = ~clock;

   corner_beat_type   corner_q [$];
   vertex_result_type vertex_q [$];

   bit                   slot_used [TABLE_SLOTS];
   logic [KW-1:0]        slot_tag  [TABLE_SLOTS];
   logic [VNUM_BITS-1:0] slot_num  [TABLE_SLOTS];
   int unsigned          next_num = 0;

   bit              req_fire = 1'b0;
   bit              rsp_fire = 1'b0;
   int              req_count = 0;
   int              mismatches = 0;
   int              cycles = 0;
   int              hold_at = 0;
   int              hold_left = 0;
   bit              hold_armed = 1'b1;
   corner_beat_type cur;
   bit              have_item = 1'b0;
   int              send_wait = 0;
   int              rsp_stall = 0;
   int              rsp_calm_left = 0;

   function automatic vertex_result_type lookup_corner(logic som, logic [AIB-1:0] pos,
                                                       logic [AIB:0] nrm, logic [AIB:0] tex);
      vertex_result_type r;
      logic [KW-1:0]     k;
      logic [63:0]       h;
      int unsigned       s;
      int                n;
      if (som) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         next_num = 0;
      end
      k = {pos, nrm, tex};
      h = 64'(pos) ^ (64'(nrm) << 1) ^ (64'(tex) << 2);
      s = int'(h % 64'(TABLE_SLOTS));
      r = '0;
      r.full = 1'b1;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (!slot_used[s]) begin
            slot_used[s] = 1'b1;
            slot_tag[s]  = k;
            slot_num[s]  = next_num[VNUM_BITS-1:0];
            r.vnum       = next_num[VNUM_BITS-1:0];
            r.is_new     = 1'b1;
            r.full       = 1'b0;
            next_num++;
            return r;
         end
         if (slot_tag[s] == k) begin
            r.vnum = slot_num[s];
            r.full = 1'b0;
            return r;
         end
         s = (s + 1) % TABLE_SLOTS;
      end
      return r;
   endfunction

   function automatic logic [AIB:0] pick_index();
      logic [31:0] w;
      int          r;
      w = $urandom();
      r = $urandom_range(0, 15);
      if (r < 4) return NO_INDEX;
      if (r == 4) return MIN_INDEX;
      if (r == 5) return MAX_INDEX;
      return w[AIB:0];
   endfunction

   // key whose hash lands on the given slot; upper position bits random
   function automatic logic [KW-1:0] key_at_slot(int slot, logic [AIB:0] nrm,
                                                 logic [AIB:0] tex);
      logic [31:0]          w;
      logic [SLOT_BITS-1:0] mix;
      logic [AIB-1:0]       pos;
      w   = $urandom();
      mix = SLOT_BITS'({nrm, 1'b0} ^ {tex, 2'b00});
      pos = w[AIB-1:0];
      pos[SLOT_BITS-1:0] = mix ^ SLOT_BITS'(slot);
      return {pos, nrm, tex};
   endfunction

   function automatic logic [KW-1:0] random_key();
      return key_at_slot($urandom_range(0, TABLE_SLOTS - 1), pick_index(), pick_index());
   endfunction

   function automatic int send_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic void push_corner(logic som, logic [KW-1:0] k, int gap, bit drain);
      corner_beat_type b;
      b.som   = som;
      b.pos   = k[KW-1 -: AIB];
      b.nrm   = k[2*AIB+1 -: AIB+1];
      b.tex   = k[AIB:0];
      b.gap   = gap;
      b.drain = drain;
      corner_q.insert(corner_q.size(), b);
   endfunction

   function automatic int rsp_gap();
      if (rsp_calm_left > 0) begin
         rsp_calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         rsp_calm_left = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic void flag_field(string field, int want, int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
   endfunction

   // sample both channels, predict on request beats, check on result beats
   always @(posedge clock) begin
      vertex_result_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_fire = 1'b1;
            req_count++;
            vertex_q.insert(vertex_q.size(),
                            lookup_corner(req_ch.start_of_model, req_ch.position_index,
                                          req_ch.nrm_index, req_ch.texture_index));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_fire = 1'b1;
            if (vertex_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat with nothing pending: vnum %0d new %0b full %0b",
                           rsp_ch.vertex_number, rsp_ch.is_new, rsp_ch.table_full);
            end else begin
               want = vertex_q.pop_front();
               if (rsp_ch.vertex_number !== want.vnum)
                  flag_field("vertex_number", want.vnum, rsp_ch.vertex_number);
               if (rsp_ch.is_new !== want.is_new)
                  flag_field("is_new", want.is_new, rsp_ch.is_new);
               if (rsp_ch.table_full !== want.full)
                  flag_field("table_full", want.full, rsp_ch.table_full);
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         have_item = 1'b0;
      end else if (!drv_valid || req_fire) begin
         if (!have_item && corner_q.size() != 0) begin
            cur       = corner_q.pop_front();
            have_item = 1'b1;
            send_wait = cur.gap;
         end
         if (!have_item) begin
            drv_valid <= 1'b0;
         end else if (send_wait > 0) begin
            send_wait--;
            drv_valid <= 1'b0;
         end else if (cur.drain && vertex_q.size() != 0) begin
            drv_valid <= 1'b0;
         end else begin
            drv_valid <= 1'b1;
            drv_som   <= cur.som;
            drv_pos   <= cur.pos;
            drv_nrm   <= cur.nrm;
            drv_tex   <= cur.tex;
            have_item = 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_fire) rsp_stall = rsp_gap();
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (hold_left == 0);
         end
      end
   end

   // long receiver hold-off at the start of the back-to-back burst
   always @(negedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && req_count >= hold_at) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [KW-1:0] ka, kb, kc, kd, ke, kf, k3;
      logic [KW-1:0] pool [16];
      int            i, j, n, pool_n, len, r;
      int            hot [3];
      bit            calm;

      // directed corners
      push_corner(1'b1, {ZERO_POS, NO_INDEX, NO_INDEX}, send_gap(0), 1'b0);
      push_corner(1'b0, {ZERO_POS, NO_INDEX, NO_INDEX}, send_gap(0), 1'b0);
      k3 = {MAX_POS, MAX_INDEX, MAX_INDEX};
      push_corner(1'b0, k3, send_gap(0), 1'b0);
      push_corner(1'b0, {MAX_POS, NO_INDEX, {(AIB+1){1'b0}}}, send_gap(0), 1'b0);
      push_corner(1'b0, {MAX_POS, {(AIB+1){1'b0}}, NO_INDEX}, send_gap(0), 1'b0);
      // indices below -1
      push_corner(1'b0, {ZERO_POS, MIN_INDEX, {{(AIB-2){1'b1}}, 3'b011}}, send_gap(0), 1'b0);
      // collision chain on one slot
      ka = key_at_slot(5, {(AIB+1){1'b0}}, {(AIB+1){1'b0}});
      kb = key_at_slot(5, {{AIB{1'b0}}, 1'b1}, {(AIB+1){1'b0}});
      kc = key_at_slot(5, NO_INDEX, {{AIB{1'b1}}, 1'b0});
      push_corner(1'b0, ka, send_gap(0), 1'b0);
      push_corner(1'b0, kb, send_gap(0), 1'b0);
      push_corner(1'b0, kc, send_gap(0), 1'b0);
      push_corner(1'b0, kc, send_gap(0), 1'b0);
      push_corner(1'b0, kb, send_gap(0), 1'b0);
      // probe wrap past the last slot
      kd = key_at_slot(TABLE_SLOTS - 1, MAX_INDEX, NO_INDEX);
      ke = key_at_slot(TABLE_SLOTS - 1, MIN_INDEX, MAX_INDEX);
      kf = key_at_slot(TABLE_SLOTS - 1, NO_INDEX, MIN_INDEX);
      push_corner(1'b0, kd, send_gap(0), 1'b0);
      push_corner(1'b0, ke, send_gap(0), 1'b0);
      push_corner(1'b0, kf, send_gap(0), 1'b0);
      push_corner(1'b0, kf, send_gap(0), 1'b0);
      push_corner(1'b0, k3, send_gap(0), 1'b0);
      push_corner(1'b0, {ZERO_POS, NO_INDEX, NO_INDEX}, send_gap(0), 1'b0);
      // restart on a known key, twice
      push_corner(1'b1, k3, send_gap(0), 1'b0);
      push_corner(1'b1, k3, send_gap(0), 1'b0);
      push_corner(1'b0, k3, send_gap(0), 1'b0);

      // back-to-back burst against a stalled receiver
      hold_at = corner_q.size() + 1;
      for (i = 0; i < 4; i++) pool[i] = random_key();
      for (i = 0; i < 32; i++)
         push_corner(i == 0, pool[$urandom_range(0, 3)], 0, i == 0);

      // many short models, past the epoch tag wrap
      for (j = 0; j < 262; j++) begin
         ka = random_key();
         push_corner(1'b1, ka, send_gap(0), j == 0);
         if (j % 8 == 0) push_corner(1'b0, ka, send_gap(0), 1'b0);
      end

      // random models: clustered pools for hits and probe chains, plus noise
      n = 0;
      while (n < RANDOM_ITEMS) begin
         calm   = ($urandom_range(0, 4) == 0);
         pool_n = $urandom_range(1, 16);
         len    = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 14);
         hot[0] = $urandom_range(0, TABLE_SLOTS - 1);
         hot[1] = $urandom_range(TABLE_SLOTS - 3, TABLE_SLOTS - 1);
         hot[2] = $urandom_range(0, TABLE_SLOTS - 1);
         for (i = 0; i < pool_n; i++)
            pool[i] = key_at_slot(hot[$urandom_range(0, 2)], pick_index(), pick_index());
         for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 65)
               ka = pool[$urandom_range(0, pool_n - 1)];
            else if (r < 90)
               ka = random_key();
            else
               ka = KW'({$urandom(), $urandom()});
            push_corner(i == 0 ? ($urandom_range(0, 9) != 0) : (r >= 97 && $urandom_range(0, 1)),
                        ka, send_gap(calm), $urandom_range(0, 49) == 0);
            n++;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (corner_q.size() != 0 || have_item || drv_valid) @(posedge clock);
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && vertex_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: vertex_key_dedup_table_unit.f
hw/rtl/vkd_pkg.sv
hw/rtl/vkd_if.sv
hw/rtl/vkd_table_mem.sv
hw/rtl/vkd_probe_ctrl.sv
hw/rtl/vertex_key_dedup_table_unit.sv
tb/sv/vertex_key_dedup_table_unit_tb.sv
